>>> rtl/rgbkc_pkg.sv
// Shared types, register indexes and constants for the RGB kernel convolution block.
`default_nettype none
package rgbkc_pkg;

  localparam int MAX_KERNEL_DEF = 5;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int ACC_BITS       = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int PIX_MAX        = 255;
  localparam int NUM_TAPS       = 25;

  localparam logic [2:0] REG_COEFS_A = 3'd0;
  localparam logic [2:0] REG_COEFS_B = 3'd1;
  localparam logic [2:0] REG_COEFS_C = 3'd2;
  localparam logic [2:0] REG_COEFS_D = 3'd3;
  localparam logic [2:0] REG_DIVISOR = 3'd4;
  localparam logic [2:0] REG_WIDTH   = 3'd5;
  localparam logic [2:0] REG_HEIGHT  = 3'd6;
  localparam logic [2:0] REG_OPTIONS = 3'd7;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_done;
  } out_t;

  // one divider stage, three color lanes
  typedef struct packed {
    logic                          valid;
    logic                          fdone;
    logic [2:0]                    neg;
    logic [2:0][ACC_BITS-1:0]      rem;
    logic [2:0][ACC_BITS-1:0]      num;
    logic [2:0][ACC_BITS-1:0]      quo;
  } div_t;

endpackage
`default_nettype wire

>>> rtl/rgb_kernel_convolution.sv
// Top level: RGB raster-stream kernel convolution with line store and divider chain.
`default_nettype none
// Pixels enter in raster order, one per input transfer; each color channel is
// convolved with a signed 8-bit kernel of radius 0..2, wrapped to 16 bits,
// divided by the divisor (toward zero) and clamped (or magnitude-capped in
// absolute mode). A result appears radius*width+radius pixels after its own
// pixel; drain commands push out the remaining results once the frame is in.
// Items are handled one at a time. An item that yields a result holds off
// further input while the engine walks the window through the single read
// port of the line store, feeds the divider chain, waits for the chain (one
// quotient bit per cell) and loads the output register, and longer while a
// stalled result still holds the output register.
// The line store is not cleared; it holds MAX_KERNEL*MAX_WIDTH pixels.
module rgb_kernel_convolution #(
  parameter int MAX_KERNEL = rgbkc_pkg::MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = rgbkc_pkg::MAX_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rgbkc_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output rgbkc_pkg::out_t      out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [63:0]     cfg_data
);

  localparam int STORE = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(STORE);
  localparam int SW    = AW + 2;       // signed address sum width
  localparam int LIN_W = 24;           // raster position, up to 4096*MAX_WIDTH
  localparam int RLIM  = (MAX_KERNEL - 1) / 2;
  localparam int DW    = rgbkc_pkg::ACC_BITS;

  localparam logic [AW-1:0] STORE_LAST = AW'(STORE - 1);
  localparam logic [12:0]   MAXW13     = 13'(MAX_WIDTH);

  // engine states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CENTRE = 3'd1;
  localparam logic [2:0] ST_TAPS   = 3'd2;
  localparam logic [2:0] ST_LAST   = 3'd3;
  localparam logic [2:0] ST_FEED   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // ---------------- configuration registers ----------------
  logic [63:0] coefs_a, coefs_b, coefs_c;
  logic [7:0]  coefs_d;
  logic [15:0] divisor;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [3:0]  options;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs_a      <= '0;
      coefs_b      <= '0;
      coefs_c      <= '0;
      coefs_d      <= '0;
      divisor      <= 16'd1;
      frame_width  <= 11'd640;
      frame_height <= 13'd480;
      options      <= 4'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbkc_pkg::REG_COEFS_A: coefs_a      <= cfg_data;
        rgbkc_pkg::REG_COEFS_B: coefs_b      <= cfg_data;
        rgbkc_pkg::REG_COEFS_C: coefs_c      <= cfg_data;
        rgbkc_pkg::REG_COEFS_D: coefs_d      <= cfg_data[7:0];
        rgbkc_pkg::REG_DIVISOR: divisor      <= cfg_data[15:0];
        rgbkc_pkg::REG_WIDTH:   frame_width  <= cfg_data[10:0];
        rgbkc_pkg::REG_HEIGHT:  frame_height <= cfg_data[12:0];
        rgbkc_pkg::REG_OPTIONS: options      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective geometry and mode
  logic [10:0] w;
  logic [12:0] h;
  logic [1:0]  r;
  logic [2:0]  ksize;
  logic [15:0] dvsr;
  logic        abs_mode, cont;
  logic [24:0][7:0] coefs;

  always_comb begin
    w = (frame_width == 11'd0) ? 11'd1 : frame_width;
    if ({2'b0, w} > MAXW13) w = MAXW13[10:0];
    h = (frame_height == 13'd0) ? 13'd1 : frame_height;
    if (h > 13'(rgbkc_pkg::MAX_HEIGHT)) h = 13'(rgbkc_pkg::MAX_HEIGHT);
    r = (options[3:2] > 2'd2) ? 2'd2 : options[3:2];
    if (r > 2'(RLIM)) r = 2'(RLIM);
    ksize = {r, 1'b1};
    dvsr  = (divisor == 16'd0) ? 16'd1 : divisor;
  end

  assign abs_mode = options[0];
  assign cont     = options[1];
  assign coefs    = {coefs_d, coefs_c, coefs_b, coefs_a};

  // ---------------- position counters ----------------
  logic [12:0]       in_row, out_row, in_row_next, out_row_next;
  logic [10:0]       in_col, out_col, in_col_next, out_col_next;
  logic [LIN_W-1:0]  in_lin, out_lin, in_lin_next, out_lin_next;
  logic [AW-1:0]     wptr, optr, wptr_next, optr_next;
  logic              draining, draining_next;

  logic [2:0]        state, state_next;
  logic              accept, do_emit, wr_en;
  logic [AW-1:0]     wr_addr;
  logic [12:0]       e_row;
  logic [10:0]       e_col;
  logic [AW-1:0]     e_ptr;
  logic              e_fdone;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [13:0]      lag;
    logic [12:0]      c_in_row, c_out_row;
    logic [10:0]      c_in_col, c_out_col;
    logic [LIN_W-1:0] c_in_lin, c_out_lin;
    logic [AW-1:0]    c_wptr, c_optr;
    logic             clr;

    lag = (14'(r) * 14'(w)) + 14'(r);
    // a new pixel after a finished frame restarts from zero
    clr       = draining && (in_data.command == rgbkc_pkg::CMD_PIXEL);
    c_in_row  = clr ? '0 : in_row;
    c_in_col  = clr ? '0 : in_col;
    c_in_lin  = clr ? '0 : in_lin;
    c_wptr    = clr ? '0 : wptr;
    c_out_row = clr ? '0 : out_row;
    c_out_col = clr ? '0 : out_col;
    c_out_lin = clr ? '0 : out_lin;
    c_optr    = clr ? '0 : optr;

    in_row_next   = in_row;
    in_col_next   = in_col;
    in_lin_next   = in_lin;
    wptr_next     = wptr;
    out_row_next  = out_row;
    out_col_next  = out_col;
    out_lin_next  = out_lin;
    optr_next     = optr;
    draining_next = draining;
    do_emit       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = c_wptr;

    if (accept) begin
      if (in_data.command == rgbkc_pkg::CMD_PIXEL) begin
        wr_en = 1'b1;
        in_row_next = c_in_row;
        in_col_next = c_in_col + 11'd1;
        if (in_col_next >= w) begin
          in_col_next = '0;
          in_row_next = c_in_row + 13'd1;
        end
        in_lin_next = c_in_lin + LIN_W'(1);
        wptr_next   = (c_wptr == STORE_LAST) ? '0 : c_wptr + AW'(1);
        do_emit = (c_out_row < h) &&
                  ({1'b0, c_in_lin} >= {1'b0, c_out_lin} + (LIN_W+1)'(lag));
        out_row_next  = c_out_row;
        out_col_next  = c_out_col;
        out_lin_next  = c_out_lin;
        optr_next     = c_optr;
        draining_next = 1'b0;
      end else if (draining) begin
        do_emit = (out_row < h);
        if (!do_emit) begin
          in_row_next = '0; in_col_next = '0; in_lin_next = '0; wptr_next = '0;
          out_row_next = '0; out_col_next = '0; out_lin_next = '0; optr_next = '0;
          draining_next = 1'b0;
        end
      end

      if (do_emit) begin
        out_col_next = out_col_next + 11'd1;
        if (out_col_next >= w) begin
          out_col_next = '0;
          out_row_next = out_row_next + 13'd1;
        end
        out_lin_next = out_lin_next + LIN_W'(1);
        optr_next    = (optr_next == STORE_LAST) ? '0 : optr_next + AW'(1);
      end

      // end of frame bookkeeping
      if (in_data.command == rgbkc_pkg::CMD_PIXEL) begin
        if (in_row_next >= h) begin
          if (out_row_next >= h) begin
            in_row_next = '0; in_col_next = '0; in_lin_next = '0; wptr_next = '0;
            out_row_next = '0; out_col_next = '0; out_lin_next = '0; optr_next = '0;
          end else begin
            draining_next = 1'b1;
          end
        end
      end else if (do_emit && out_row_next >= h) begin
        in_row_next = '0; in_col_next = '0; in_lin_next = '0; wptr_next = '0;
        out_row_next = '0; out_col_next = '0; out_lin_next = '0; optr_next = '0;
        draining_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row   <= '0;
      in_col   <= '0;
      in_lin   <= '0;
      wptr     <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_lin  <= '0;
      optr     <= '0;
      draining <= 1'b0;
    end else begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_lin   <= in_lin_next;
      wptr     <= wptr_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_lin  <= out_lin_next;
      optr     <= optr_next;
      draining <= draining_next;
    end
  end

  // latch the position being emitted; counters move on at once
  always_ff @(posedge clk) begin
    if (accept && do_emit) begin
      if (in_data.command == rgbkc_pkg::CMD_PIXEL && draining) begin
        e_row <= '0;
        e_col <= '0;
        e_ptr <= '0;
      end else begin
        e_row <= out_row;
        e_col <= out_col;
        e_ptr <= optr;
      end
    end
  end

  // frame_done is taken from the advanced output row
  logic fdone_now;
  always_comb begin
    logic [12:0] base_row;
    logic [10:0] base_col;
    base_row = (in_data.command == rgbkc_pkg::CMD_PIXEL && draining) ? '0 : out_row;
    base_col = (in_data.command == rgbkc_pkg::CMD_PIXEL && draining) ? '0 : out_col;
    fdone_now = (base_col + 11'd1 >= w) ? (base_row + 13'd1 >= h) : (base_row >= h);
  end

  always_ff @(posedge clk) begin
    if (accept && do_emit) e_fdone <= fdone_now;
  end

  // ---------------- line store ----------------
  logic [23:0]   mem [STORE];
  logic [AW-1:0] rd_addr;
  logic [23:0]   rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    rd_data <= mem[rd_addr];
  end

  // ---------------- window walk ----------------
  logic [2:0]  ti, tj;
  logic [4:0]  slot;
  logic        tap_inb;
  logic [23:0] centre_px;
  logic        d_valid, d_cent, d_inb;
  logic [7:0]  d_coef;
  logic [2:0][DW-1:0] acc;

  always_comb begin
    logic signed [3:0]    ki, kj;
    logic signed [17:0]   off;
    logic signed [SW-1:0] sum;
    logic signed [14:0]   rr;
    logic signed [12:0]   cc;
    ki  = $signed({1'b0, ti}) - $signed({2'b0, r});
    kj  = $signed({1'b0, tj}) - $signed({2'b0, r});
    off = 18'(18'($signed(ki)) * $signed({7'b0, w})) + 18'($signed(kj));
    sum = $signed({2'b0, e_ptr}) + $signed(off[SW-1:0]);
    if (sum < 0) sum = sum + SW'(STORE);
    else if (sum >= SW'(STORE)) sum = sum - SW'(STORE);
    rr = $signed({2'b0, e_row}) + 15'(ki);
    cc = $signed({2'b0, e_col}) + 13'(kj);
    tap_inb = (rr >= 0) && (rr < $signed({2'b0, h})) &&
              (cc >= 0) && (cc < $signed({2'b0, w}));
    rd_addr = (state == ST_CENTRE) ? e_ptr : sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CENTRE) begin
      ti   <= '0;
      tj   <= '0;
      slot <= '0;
    end else if (state == ST_TAPS) begin
      slot <= slot + 5'd1;
      if (tj == ksize - 3'd1) begin
        tj <= '0;
        ti <= ti + 3'd1;
      end else begin
        tj <= tj + 3'd1;
      end
    end
    d_inb  <= tap_inb;
    d_coef <= coefs[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      d_cent  <= 1'b0;
    end else begin
      d_valid <= (state == ST_TAPS);
      d_cent  <= (state == ST_CENTRE);
    end
  end

  // multiply-accumulate, wrapping at the accumulator width
  always_ff @(posedge clk) begin
    logic [23:0] px;
    px = d_inb ? rd_data : (cont ? centre_px : 24'd0);
    if (d_cent) centre_px <= rd_data;
    if (state == ST_CENTRE) begin
      acc <= '0;
    end else if (d_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= acc[ch] + (DW'($signed({1'b0, px[23-8*ch -: 8]})) *
                              DW'($signed(d_coef)));
      end
    end
  end

  // ---------------- divider chain ----------------
  rgbkc_pkg::div_t stage [DW+1];

  always_comb begin
    stage[0]       = '0;
    stage[0].valid = (state == ST_FEED);
    stage[0].fdone = e_fdone;
    for (int ch = 0; ch < 3; ch++) begin
      stage[0].neg[ch] = acc[ch][DW-1];
      stage[0].num[ch] = acc[ch][DW-1] ? DW'(-acc[ch]) : acc[ch];
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_div
    rgbkc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .dvsr (dvsr),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  // clamp the quotient
  rgbkc_pkg::out_t res, res_next;
  always_comb begin
    logic [DW-1:0] q;
    logic [7:0]    v [3];
    for (int ch = 0; ch < 3; ch++) begin
      q = stage[DW].quo[ch];
      if (stage[DW].neg[ch] && !abs_mode) v[ch] = 8'd0;
      else if (q > DW'(rgbkc_pkg::PIX_MAX)) v[ch] = 8'(rgbkc_pkg::PIX_MAX);
      else v[ch] = q[7:0];
    end
    res_next = '{red_out: v[0], green_out: v[1], blue_out: v[2],
                 frame_done: stage[DW].fdone};
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && stage[DW].valid) res <= res_next;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && do_emit) state_next = ST_CENTRE;
      ST_CENTRE: state_next = ST_TAPS;
      ST_TAPS:   if (ti == ksize - 3'd1 && tj == ksize - 3'd1) state_next = ST_LAST;
      ST_LAST:   state_next = ST_FEED;
      ST_FEED:   state_next = ST_DIV;
      ST_DIV:    if (stage[DW].valid) state_next = ST_OUT;
      ST_OUT:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // output register: loads a finished result, holds it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) out_data <= res;
  end

  // ---------------- checks ----------------
  a_div_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    stage[DW].valid |-> state == ST_DIV)
    else $error("divider result outside wait state");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAPS |-> slot < 5'(rgbkc_pkg::NUM_TAPS))
    else $error("coefficient slot out of range");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("output valid without finished result");

endmodule
`default_nettype wire

>>> rtl/rgbkc_div_cell.sv
// One restoring-division cell: produces one quotient bit per lane and hands on.
`default_nettype none
module rgbkc_div_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rgbkc_pkg::ACC_BITS-1:0] dvsr,
  input  wire rgbkc_pkg::div_t               din,
  output rgbkc_pkg::div_t                    dout
);

  rgbkc_pkg::div_t step;

  always_comb begin
    logic [rgbkc_pkg::ACC_BITS:0] t;
    step = din;
    for (int ch = 0; ch < 3; ch++) begin
      t = {din.rem[ch], din.num[ch][rgbkc_pkg::ACC_BITS-1]};
      step.num[ch] = {din.num[ch][rgbkc_pkg::ACC_BITS-2:0], 1'b0};
      if (t >= {1'b0, dvsr}) begin
        step.rem[ch] = rgbkc_pkg::ACC_BITS'(t - {1'b0, dvsr});
        step.quo[ch] = {din.quo[ch][rgbkc_pkg::ACC_BITS-2:0], 1'b1};
      end else begin
        step.rem[ch] = t[rgbkc_pkg::ACC_BITS-1:0];
        step.quo[ch] = {din.quo[ch][rgbkc_pkg::ACC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout <= '0;
    else     dout <= step;
  end

endmodule
`default_nettype wire

>>> verif/rgbkc_checker.sv
// Checker: watches the pixel, result and register channels, predicts and compares results.
module rgbkc_checker
  import rgbkc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_stall,
  input  wire in_t   in_data,
  input  wire logic  out_valid,
  input  wire logic  out_stall,
  input  wire out_t  out_data,
  input  wire logic  cfg_valid,
  input  wire logic  cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int         fail_count,
  output int         pixels_pending,
  output int         pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = MAX_KERNEL_DEF * MAX_WIDTH_DEF;

  logic [63:0] coefs_a, coefs_b, coefs_c;
  logic [7:0]  coefs_d;
  logic [15:0] div_reg;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [3:0]  opt_reg;

  logic [23:0] pix_store [STORE_DEPTH];
  int unsigned in_row, in_col, out_row, out_col;
  bit          flushing;
  out_t        filtered_q [$];

  function automatic int unsigned act_width();
    int unsigned w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned act_height();
    int unsigned h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int act_radius();
    int r = opt_reg[3:2];
    if (r > 2) r = 2;
    return r;
  endfunction

  function automatic int tap_weight(int unsigned slot);
    logic [7:0] b;
    if (slot < 8) b = coefs_a[8*slot +: 8];
    else if (slot < 16) b = coefs_b[8*(slot-8) +: 8];
    else if (slot < 24) b = coefs_c[8*(slot-16) +: 8];
    else if (slot == 24) b = coefs_d;
    else b = 8'd0;
    return int'($signed(b));
  endfunction

  function automatic logic [7:0] scale_clamp(logic [31:0] acc);
    logic signed [15:0] s = acc[15:0];
    int d = div_reg;
    int q;
    if (d == 0) d = 1;
    q = int'(s) / d;
    if (opt_reg[0]) begin
      if (q < 0) q = -q;
    end else if (q < 0) begin
      q = 0;
    end
    if (q > PIX_MAX) q = PIX_MAX;
    return q[7:0];
  endfunction

  function automatic void clear_position();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0; flushing = 0;
  endfunction

  // Filter the pixel at the output position and move the output position on.
  function automatic out_t filter_next();
    int unsigned w = act_width();
    int unsigned h = act_height();
    int r = act_radius();
    int sz = 2*r + 1;
    bit edge_copy = opt_reg[1];
    logic [23:0] center = pix_store[(out_row*w + out_col) % STORE_DEPTH];
    logic [31:0] acc [3];
    logic [23:0] px;
    int rr, cc, k, v;
    out_t res;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int ki = -r; ki <= r; ki++) begin
      for (int kj = -r; kj <= r; kj++) begin
        rr = int'(out_row) + ki;
        cc = int'(out_col) + kj;
        k = tap_weight((ki + r)*sz + (kj + r));
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
          px = pix_store[(rr*w + cc) % STORE_DEPTH];
        else
          px = edge_copy ? center : 24'd0;
        for (int c = 0; c < 3; c++) begin
          v = px[16-8*c +: 8];
          acc[c] = acc[c] + 32'(v * k);
        end
      end
    end
    res.red_out   = scale_clamp(acc[0]);
    res.green_out = scale_clamp(acc[1]);
    res.blue_out  = scale_clamp(acc[2]);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    res.frame_done = (out_row >= h);
    return res;
  endfunction

  function automatic void take_item(in_t it);
    int unsigned w = act_width();
    int unsigned h = act_height();
    int unsigned r = act_radius();
    int unsigned lin, lag;
    if (it.command == CMD_PIXEL) begin
      if (flushing) clear_position();
      lin = in_row*w + in_col;
      pix_store[lin % STORE_DEPTH] = {it.red_in, it.green_in, it.blue_in};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      lag = r*w + r;
      if (out_row < h && lin >= out_row*w + out_col + lag)
        filtered_q.push_back(filter_next());
      if (in_row >= h) begin
        if (out_row >= h) clear_position();
        else flushing = 1;
      end
    end else if (flushing) begin
      if (out_row >= h) begin
        clear_position();
      end else begin
        filtered_q.push_back(filter_next());
        if (out_row >= h) clear_position();
      end
    end
  endfunction

  function automatic void compare_result(out_t got);
    out_t exp_r;
    if (filtered_q.size() == 0) begin
      $error("unexpected result transfer %p", got);
      fail_count++;
      return;
    end
    exp_r = filtered_q.pop_front();
    pixels_checked++;
    if (got.red_out !== exp_r.red_out) begin
      $error("red_out expected %0d got %0d", exp_r.red_out, got.red_out);
      fail_count++;
    end
    if (got.green_out !== exp_r.green_out) begin
      $error("green_out expected %0d got %0d", exp_r.green_out, got.green_out);
      fail_count++;
    end
    if (got.blue_out !== exp_r.blue_out) begin
      $error("blue_out expected %0d got %0d", exp_r.blue_out, got.blue_out);
      fail_count++;
    end
    if (got.frame_done !== exp_r.frame_done) begin
      $error("frame_done expected %0d got %0d", exp_r.frame_done, got.frame_done);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coefs_a = 0; coefs_b = 0; coefs_c = 0; coefs_d = 0;
      div_reg = 1; width_reg = 640; height_reg = 480; opt_reg = 4;
      clear_position();
      filtered_q.delete();
      fail_count = 0;
      pixels_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEFS_A: coefs_a = cfg_data;
          REG_COEFS_B: coefs_b = cfg_data;
          REG_COEFS_C: coefs_c = cfg_data;
          REG_COEFS_D: coefs_d = cfg_data[7:0];
          REG_DIVISOR: div_reg = cfg_data[15:0];
          REG_WIDTH:   width_reg = cfg_data[10:0];
          REG_HEIGHT:  height_reg = cfg_data[12:0];
          REG_OPTIONS: opt_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_result(out_data);
      if (in_valid && !in_stall) take_item(in_data);
    end
    pixels_pending <= filtered_q.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top: drives pixel frames, drains and register settings; reports the verdict.
module tb_top;
  import rgbkc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL   = 1350;   // includes one full-width row
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_COEFS_A;
  logic [63:0] cfg_data = '0;

  int fail_count, pixels_pending, pixels_checked;
  int items_sent = 0;
  int settings_used = 0;
  int cycles = 0;
  bit quiet = 0;       // no idling on either side near the end
  bit hold_req = 0;    // ask the receiver for one long hold-off

  always #10 clk = ~clk;

  rgb_kernel_convolution u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  rgbkc_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pixels_pending, .pixels_checked
  );

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off so the block backs
  // up and stalls its input while the sender keeps offering pixels.
  initial begin
    bit held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid still high so back-to-back items need no second assignment.
  task automatic send_item(in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic send_pixel();
    in_t it;
    logic [7:0] ch [3];
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 7))
        0: ch[c] = 8'd0;
        1: ch[c] = 8'd255;
        default: ch[c] = 8'($urandom_range(0, 255));
      endcase
    end
    it.command = CMD_PIXEL;
    it.red_in = ch[0]; it.green_in = ch[1]; it.blue_in = ch[2];
    sender_gap();
    send_item(it);
  endtask

  task automatic send_drain();
    in_t it;
    it.command = CMD_DRAIN;
    it.red_in = 8'($urandom); it.green_in = 8'($urandom); it.blue_in = 8'($urandom);
    sender_gap();
    send_item(it);
  endtask

  // Sender pauses until every expected result is out and the block is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes every register; returns the geometry the block will actually use.
  task automatic apply_setting(logic [63:0] ca, logic [63:0] cb, logic [63:0] cc,
                               logic [7:0] cd, logic [15:0] dv, logic [10:0] wd,
                               logic [12:0] ht, logic [3:0] op,
                               output int w, output int h, output int r);
    wait_idle();
    write_reg(REG_COEFS_A, ca);
    write_reg(REG_COEFS_B, cb);
    write_reg(REG_COEFS_C, cc);
    write_reg(REG_COEFS_D, {56'd0, cd});
    write_reg(REG_DIVISOR, {48'd0, dv});
    write_reg(REG_WIDTH, {53'd0, wd});
    write_reg(REG_HEIGHT, {51'd0, ht});
    write_reg(REG_OPTIONS, {60'd0, op});
    w = (wd == 0) ? 1 : (wd > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : wd);
    h = (ht == 0) ? 1 : (ht > MAX_HEIGHT ? MAX_HEIGHT : ht);
    r = (op[3:2] > 2) ? 2 : op[3:2];
    settings_used++;
  endtask

  // One frame of pixels, then the drains that flush its pending results. When
  // cut is set only part of the drains go out and the next frame drops the rest.
  task automatic run_frame(int w, int h, int r, bit cut);
    int npix = w*h;
    int lag = r*w + r;
    int ndrain = (npix > lag) ? lag : npix;
    for (int i = 0; i < npix; i++) send_pixel();
    if (cut && ndrain > 0) ndrain = $urandom_range(0, ndrain - 1);
    for (int i = 0; i < ndrain; i++) send_drain();
    if (!cut && $urandom_range(0, 4) == 0) send_drain();  // nothing left to flush
  endtask

  function automatic logic [63:0] rand_coefs(int style);
    case (style)
      0: return {8{8'h7F}};
      1: return {8{8'h80}};
      2: return {8{8'h01}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int w, h, r, nframes, style;
    logic [15:0] dv;
    logic [3:0] op;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: drain with nothing pending, then saturating kernels with the
    // missing divisor and oversized radius code, then degenerate geometry.
    send_drain();
    apply_setting({8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, 8'h80, 16'd0, 11'd3, 13'd3,
                  4'b1101, w, h, r);
    run_frame(w, h, r, 0);
    apply_setting({8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 8'h7F, 16'd1, 11'd4, 13'd2,
                  4'b1000, w, h, r);
    run_frame(w, h, r, 1);       // flush cut short by the next frame
    run_frame(w, h, r, 0);
    apply_setting(64'hFF, 64'd0, 64'd0, 8'd0, 16'd65535, 11'd0, 13'd0, 4'b0010,
                  w, h, r);
    run_frame(w, h, r, 0);
    // Widest row, radius 0 so it stays quick.
    apply_setting({$urandom, $urandom}, 64'd0, 64'd0, 8'd0, 16'd2, 11'd2047, 13'd1,
                  4'b0011, w, h, r);
    run_frame(w, h, r, 0);

    // Random settings and frames.
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - 200) quiet = 1;
      style = $urandom_range(0, 9);
      case ($urandom_range(0, 6))
        0: dv = 16'd0;
        1: dv = 16'd1;
        2: dv = 16'd65535;
        3: dv = 16'($urandom_range(2, 9));
        default: dv = 16'($urandom_range(1, 300));
      endcase
      op = 4'($urandom_range(0, 15));
      apply_setting(rand_coefs(style), rand_coefs(style), rand_coefs(style),
                    8'($urandom_range(0, 255)), dv, 11'($urandom_range(1, 9)),
                    13'($urandom_range(1, 7)), op, w, h, r);
      if (settings_used == 5) hold_req = 1;
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++)
        run_frame(w, h, r, (f < nframes - 1) && ($urandom_range(0, 3) == 0));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d input transfers under %0d register settings; %0d results compared.",
             items_sent, settings_used, pixels_checked);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
